FILE: design/pfau_pkg.sv
// Shared types and constants of the prime field arithmetic unit.
`timescale 1ns / 1ps

package pfau_pkg;

	localparam int VALUE_WIDTH_DEF = 64;
	localparam int MOD_W           = 31;

	localparam logic [5:0] DIV_LAST_LONG  = 6'd63;
	localparam logic [5:0] DIV_LAST_SHORT = 6'd31;

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_SUB = 2'd1,
		MODE_MUL = 2'd2,
		MODE_DIV = 2'd3
	} mode_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_DIV_INIT,
		CMD_DIV_STEP,
		CMD_FIX_A,
		CMD_FIX_B,
		CMD_FADD,
		CMD_FSUB,
		CMD_FMUL,
		CMD_RES_REM,
		CMD_IADD,
		CMD_ISUB,
		CMD_IMUL0,
		CMD_IMUL1,
		CMD_IMUL2,
		CMD_IDIV_FIN,
		CMD_ZERO_FLAG,
		CMD_EU_INIT,
		CMD_EU_MUL,
		CMD_EU_UPD,
		CMD_EU_FIN
	} cmd_op_t;

	typedef enum logic [2:0] {
		DSRC_A,
		DSRC_B,
		DSRC_PROD,
		DSRC_INT,
		DSRC_EUC
	} div_src_t;

	typedef struct packed {
		cmd_op_t  op;
		div_src_t src;
	} dp_cmd_t;

	typedef struct packed {
		logic  field;
		mode_t mode;
		logic  b_zero;
		logic  r1_zero;
		logic  r0_one;
	} dp_status_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_RA_RUN,
		ST_RA_FIX,
		ST_RB_INIT,
		ST_RB_RUN,
		ST_RB_FIX,
		ST_FOP,
		ST_FMUL,
		ST_FRED_INIT,
		ST_FRED_RUN,
		ST_FRED_FIN,
		ST_EU_CHECK,
		ST_EU_DIV,
		ST_EU_MUL,
		ST_EU_UPD,
		ST_EU_FIN,
		ST_IMUL1,
		ST_IMUL2,
		ST_IDIV_RUN,
		ST_IDIV_FIN,
		ST_DONE
	} state_t;

endpackage

FILE: design/pfau_in_if.sv
// Request channel: operation and two operands.
`timescale 1ns / 1ps

interface pfau_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [63:0] operand_a;
	logic [63:0] operand_b;

	modport source (output valid, mode, operand_a, operand_b, input ready);
	modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

FILE: design/pfau_out_if.sv
// Response channel: result and no-inverse flag.
`timescale 1ns / 1ps

interface pfau_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_value;
	logic        no_inverse;

	modport source (output valid, result_value, no_inverse, input ready);
	modport sink   (input valid, result_value, no_inverse, output ready);
endinterface

FILE: design/pfau_dp.sv
// Datapath: operand registers, shift-subtract divider, multiplier, Euclid registers.
`timescale 1ns / 1ps

module pfau_dp
	import pfau_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [MOD_W-1:0]   cfg_wdata,
	input  dp_cmd_t            cmd,
	input  logic [1:0]         in_mode,
	input  logic [63:0]        in_a,
	input  logic [63:0]        in_b,
	output dp_status_t         status,
	output logic [63:0]        res,
	output logic               flag
);

	localparam logic [63:0] WMASK = {64{1'b1}} >> (64 - VALUE_WIDTH);

	function automatic logic [63:0] sext_w(input logic [63:0] v);
		logic [63:0] m;
		m = v & WMASK;
		if (v[VALUE_WIDTH-1]) m = m | ~WMASK;
		return m;
	endfunction

	logic [MOD_W-1:0] p_q;
	logic [1:0]       mode_q;
	logic [63:0]      a_q, b_q, prod_q, rem_q, quo_q, dsr_q, res_q;
	logic             flag_q;
	logic [MOD_W-1:0] r0_q, r1_q;
	logic signed [33:0] t0_q, t1_q, qprod_q;

	logic [63:0] abs_a, abs_b, p64;
	logic [64:0] rem_sh;
	logic        ge;
	logic [61:0] fprod;
	logic [63:0] pp;
	logic [31:0] fsum, fdif;
	logic signed [66:0] eprod;
	logic signed [33:0] tfix;

	always_comb begin
		p64    = {33'd0, p_q};
		abs_a  = a_q[63] ? 64'd0 - a_q : a_q;
		abs_b  = b_q[63] ? 64'd0 - b_q : b_q;
		rem_sh = {rem_q, quo_q[63]};
		ge     = rem_sh >= {1'b0, dsr_q};
		fprod  = a_q[30:0] * b_q[30:0];
		pp     = (cmd.op == CMD_IMUL1) ? a_q[31:0] * b_q[63:32] : a_q[63:32] * b_q[31:0];
		fsum   = a_q[31:0] + b_q[31:0];
		fsum   = (fsum >= {1'b0, p_q}) ? fsum - {1'b0, p_q} : fsum;
		fdif   = (a_q[31:0] >= b_q[31:0]) ? a_q[31:0] - b_q[31:0]
		                                  : a_q[31:0] + {1'b0, p_q} - b_q[31:0];
		eprod  = $signed({1'b0, quo_q[31:0]}) * t1_q;
		tfix   = t0_q + $signed({3'd0, p_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
		end else if (cfg_we) begin
			p_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CMD_LOAD: begin
				mode_q <= in_mode;
				a_q    <= sext_w(in_a);
				b_q    <= sext_w(in_b);
			end
			CMD_DIV_INIT: begin
				rem_q <= '0;
				unique case (cmd.src)
					DSRC_A:    begin quo_q <= abs_a;  dsr_q <= p64;   end
					DSRC_B:    begin quo_q <= abs_b;  dsr_q <= p64;   end
					DSRC_PROD: begin quo_q <= prod_q; dsr_q <= p64;   end
					DSRC_INT:  begin quo_q <= abs_a;  dsr_q <= abs_b; end
					DSRC_EUC: begin
						quo_q <= {1'b0, r0_q, 32'd0};
						dsr_q <= {33'd0, r1_q};
					end
					default:   begin quo_q <= abs_a;  dsr_q <= p64;   end
				endcase
			end
			CMD_DIV_STEP: begin
				rem_q <= ge ? (rem_sh[63:0] - dsr_q) : rem_sh[63:0];
				quo_q <= {quo_q[62:0], ge};
			end
			CMD_FIX_A: a_q <= (a_q[63] && rem_q != 0) ? p64 - rem_q : rem_q;
			CMD_FIX_B: b_q <= (b_q[63] && rem_q != 0) ? p64 - rem_q : rem_q;
			CMD_FADD: begin res_q <= {32'd0, fsum}; flag_q <= 1'b0; end
			CMD_FSUB: begin res_q <= {32'd0, fdif}; flag_q <= 1'b0; end
			CMD_FMUL: prod_q <= {2'd0, fprod};
			CMD_RES_REM: begin res_q <= rem_q; flag_q <= 1'b0; end
			CMD_IADD: begin res_q <= sext_w(a_q + b_q); flag_q <= 1'b0; end
			CMD_ISUB: begin res_q <= sext_w(a_q - b_q); flag_q <= 1'b0; end
			CMD_IMUL0: prod_q <= a_q[31:0] * b_q[31:0];
			CMD_IMUL1: prod_q <= prod_q + {pp[31:0], 32'd0};
			CMD_IMUL2: begin
				res_q  <= sext_w(prod_q + {pp[31:0], 32'd0});
				flag_q <= 1'b0;
			end
			CMD_IDIV_FIN: begin
				res_q  <= sext_w((a_q[63] ^ b_q[63]) ? 64'd0 - quo_q : quo_q);
				flag_q <= 1'b0;
			end
			CMD_ZERO_FLAG: begin res_q <= '0; flag_q <= 1'b1; end
			CMD_EU_INIT: begin
				r0_q <= p_q;
				r1_q <= b_q[MOD_W-1:0];
				t0_q <= '0;
				t1_q <= 34'sd1;
			end
			CMD_EU_MUL: qprod_q <= eprod[33:0];
			CMD_EU_UPD: begin
				r0_q <= r1_q;
				r1_q <= rem_q[MOD_W-1:0];
				t0_q <= t1_q;
				t1_q <= t0_q - qprod_q;
			end
			CMD_EU_FIN: b_q <= {30'd0, (t0_q[33] ? tfix : t0_q)};
			default: ;
		endcase
	end

	assign status.field   = (p_q != '0);
	assign status.mode    = mode_t'(mode_q);
	assign status.b_zero  = (b_q == '0);
	assign status.r1_zero = (r1_q == '0);
	assign status.r0_one  = (r0_q == {{(MOD_W-1){1'b0}}, 1'b1});
	assign res  = res_q;
	assign flag = flag_q;

endmodule

FILE: design/pfau_ctrl.sv
// Controller: sequences the datapath through reduction, arithmetic and inversion.
`timescale 1ns / 1ps

module pfau_ctrl
	import pfau_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       out_free,
	output logic       done,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t     state_q, state_d;
	logic [5:0] cnt_q;
	logic       last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.op == CMD_DIV_INIT) cnt_q <= '0;
			else if (cmd.op == CMD_DIV_STEP) cnt_q <= cnt_q + 6'd1;
		end
	end

	assign last = (state_q == ST_EU_DIV) ? (cnt_q == DIV_LAST_SHORT)
	                                     : (cnt_q == DIV_LAST_LONG);

	always_comb begin
		state_d  = state_q;
		cmd.op   = CMD_NONE;
		cmd.src  = DSRC_A;
		in_ready = 1'b0;
		done     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = CMD_LOAD;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (status.field) begin
					cmd.op  = CMD_DIV_INIT;
					cmd.src = DSRC_A;
					state_d = ST_RA_RUN;
				end else begin
					unique case (status.mode)
						MODE_ADD: begin cmd.op = CMD_IADD;  state_d = ST_DONE;  end
						MODE_SUB: begin cmd.op = CMD_ISUB;  state_d = ST_DONE;  end
						MODE_MUL: begin cmd.op = CMD_IMUL0; state_d = ST_IMUL1; end
						MODE_DIV: begin
							if (status.b_zero) begin
								cmd.op  = CMD_ZERO_FLAG;
								state_d = ST_DONE;
							end else begin
								cmd.op  = CMD_DIV_INIT;
								cmd.src = DSRC_INT;
								state_d = ST_IDIV_RUN;
							end
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_RA_RUN: begin
				cmd.op = CMD_DIV_STEP;
				if (last) state_d = ST_RA_FIX;
			end
			ST_RA_FIX: begin cmd.op = CMD_FIX_A; state_d = ST_RB_INIT; end
			ST_RB_INIT: begin
				cmd.op  = CMD_DIV_INIT;
				cmd.src = DSRC_B;
				state_d = ST_RB_RUN;
			end
			ST_RB_RUN: begin
				cmd.op = CMD_DIV_STEP;
				if (last) state_d = ST_RB_FIX;
			end
			ST_RB_FIX: begin cmd.op = CMD_FIX_B; state_d = ST_FOP; end
			ST_FOP: begin
				unique case (status.mode)
					MODE_ADD: begin cmd.op = CMD_FADD; state_d = ST_DONE; end
					MODE_SUB: begin cmd.op = CMD_FSUB; state_d = ST_DONE; end
					MODE_MUL: state_d = ST_FMUL;
					MODE_DIV: begin
						if (status.b_zero) begin
							cmd.op  = CMD_ZERO_FLAG;
							state_d = ST_DONE;
						end else begin
							cmd.op  = CMD_EU_INIT;
							state_d = ST_EU_CHECK;
						end
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_FMUL: begin cmd.op = CMD_FMUL; state_d = ST_FRED_INIT; end
			ST_FRED_INIT: begin
				cmd.op  = CMD_DIV_INIT;
				cmd.src = DSRC_PROD;
				state_d = ST_FRED_RUN;
			end
			ST_FRED_RUN: begin
				cmd.op = CMD_DIV_STEP;
				if (last) state_d = ST_FRED_FIN;
			end
			ST_FRED_FIN: begin cmd.op = CMD_RES_REM; state_d = ST_DONE; end
			ST_EU_CHECK: begin
				if (status.r1_zero) begin
					state_d = ST_EU_FIN;
				end else begin
					cmd.op  = CMD_DIV_INIT;
					cmd.src = DSRC_EUC;
					state_d = ST_EU_DIV;
				end
			end
			ST_EU_DIV: begin
				cmd.op = CMD_DIV_STEP;
				if (last) state_d = ST_EU_MUL;
			end
			ST_EU_MUL: begin cmd.op = CMD_EU_MUL; state_d = ST_EU_UPD;   end
			ST_EU_UPD: begin cmd.op = CMD_EU_UPD; state_d = ST_EU_CHECK; end
			ST_EU_FIN: begin
				if (status.r0_one) begin
					cmd.op  = CMD_EU_FIN;
					state_d = ST_FMUL;
				end else begin
					cmd.op  = CMD_ZERO_FLAG;
					state_d = ST_DONE;
				end
			end
			ST_IMUL1: begin cmd.op = CMD_IMUL1; state_d = ST_IMUL2; end
			ST_IMUL2: begin cmd.op = CMD_IMUL2; state_d = ST_DONE;  end
			ST_IDIV_RUN: begin
				cmd.op = CMD_DIV_STEP;
				if (last) state_d = ST_IDIV_FIN;
			end
			ST_IDIV_FIN: begin cmd.op = CMD_IDIV_FIN; state_d = ST_DONE; end
			ST_DONE: begin
				if (out_free) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: design/prime_field_arithmetic_unit.sv
// Top level of the prime field arithmetic unit: controller, datapath, output register.
`timescale 1ns / 1ps

// Modular arithmetic over GF(p) with a runtime modulus, or plain signed integer
// arithmetic when the modulus register holds zero. One beat is worked at a time;
// ready is high only while the unit is idle, and the finished result sits in an
// output register, so a new beat can enter while the previous result waits.
// Long operations run on a single shift-subtract divider that retires one quotient
// bit per cycle. Integer multiply sums three 32x32 partial products and integer
// divide runs on the divider. Field add/sub reduce both operands (64 divider steps
// each); field multiply adds a 64-step reduction of the product. Field divide runs
// extended Euclid, each step a 32-step quotient, a multiply and an update, up to
// about 45 steps for a 31-bit modulus, then the multiply and reduction. A zero or
// non-invertible divisor returns 0 with no_inverse set. The user must write
// field_modulus through cfg_we/cfg_wdata only while the unit is idle; the block
// itself does not enforce this.

module prime_field_arithmetic_unit
	import pfau_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [MOD_W-1:0] cfg_wdata,
	pfau_in_if.sink          req,
	pfau_out_if.source       rsp
);

	dp_cmd_t     cmd;
	dp_status_t  status;
	logic        done;
	logic        out_free;
	logic [63:0] res;
	logic        flag;

	logic        out_valid_q;
	logic [63:0] out_value_q;
	logic        out_flag_q;

	// output register is free when empty or being drained this cycle
	assign out_free = !out_valid_q || rsp.ready;

	pfau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_free (out_free),
		.done     (done),
		.status   (status),
		.cmd      (cmd)
	);

	pfau_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.in_mode   (req.mode),
		.in_a      (req.operand_a),
		.in_b      (req.operand_b),
		.status    (status),
		.res       (res),
		.flag      (flag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_value_q <= res;
			out_flag_q  <= flag;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = out_value_q;
	assign rsp.no_inverse   = out_flag_q;

endmodule

FILE: tb/pfau_tb_if.sv
// Testbench package: shared verdict text.
`timescale 1ns / 1ps

package pfau_tb_pkg;

	localparam string PASS_TXT = "RESULT: OK";

endpackage

FILE: tb/pfau_checker.sv
// Scoreboard for the prime field arithmetic unit: predicts each result and compares it.
`timescale 1ns / 1ps

module pfau_checker
	import pfau_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [MOD_W-1:0] cfg_wdata,
	pfau_in_if               req,
	pfau_out_if              rsp,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic [63:0] value;
		logic        no_inv;
	} answer_t;

	answer_t        answers[$];
	logic [63:0]    modulus;

	function automatic logic [63:0] field_reduce(logic [63:0] v, logic [63:0] p);
		logic [63:0] mag;
		logic [63:0] r;
		mag = v[63] ? -v : v;
		r = mag % p;
		if (v[63] && r != 0)
			r = p - r;
		return r;
	endfunction

	// extended Euclid; ok is cleared when no inverse exists
	function automatic logic [63:0] field_inverse(logic [63:0] b, logic [63:0] p,
			output logic ok);
		longint r0, r1, t0, t1, q, tmp;
		r0 = p;
		r1 = b;
		t0 = 0;
		t1 = 1;
		while (r1 != 0) begin
			q = r0 / r1;
			tmp = r0 - q * r1;
			r0 = r1;
			r1 = tmp;
			tmp = t0 - q * t1;
			t0 = t1;
			t1 = tmp;
		end
		ok = (r0 == 1);
		t0 = t0 % longint'(p);
		if (t0 < 0)
			t0 += p;
		return t0;
	endfunction

	function automatic answer_t compute_answer(mode_t m, logic [63:0] a, logic [63:0] b,
			logic [63:0] p);
		answer_t     ans;
		logic [63:0] ra, rb, inv, q;
		logic        ok;
		ans = '0;
		if (p != 0) begin
			ra = field_reduce(a, p);
			rb = field_reduce(b, p);
			case (m)
				MODE_ADD: ans.value = (ra + rb) % p;
				MODE_SUB: ans.value = (ra + p - rb) % p;
				MODE_MUL: ans.value = (ra * rb) % p;
				default: begin
					ok = 0;
					if (rb != 0)
						inv = field_inverse(rb, p, ok);
					if (ok)
						ans.value = (ra * inv) % p;
					else
						ans.no_inv = 1;
				end
			endcase
		end else begin
			case (m)
				MODE_ADD: ans.value = a + b;
				MODE_SUB: ans.value = a - b;
				MODE_MUL: ans.value = a * b;
				default: begin
					if (b == 0) begin
						ans.no_inv = 1;
					end else begin
						q = (a[63] ? -a : a) / (b[63] ? -b : b);
						ans.value = (a[63] != b[63]) ? -q : q;
					end
				end
			endcase
		end
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t got, want;
		if (!arst_n) begin
			modulus = 0;
			fail_count = 0;
			answers.delete();
			pending = 0;
		end else begin
			if (req.valid && req.ready)
				answers.push_back(compute_answer(mode_t'(req.mode), req.operand_a,
					req.operand_b, modulus));
			if (rsp.valid && rsp.ready) begin
				got.value = rsp.result_value;
				got.no_inv = rsp.no_inverse;
				if (answers.size() == 0) begin
					$display("%0t: unexpected beat value=%h flag=%b", $time,
						got.value, got.no_inv);
					fail_count++;
				end else begin
					want = answers.pop_front();
					if (got.value !== want.value) begin
						$display("%0t: result_value expected %h actual %h", $time,
							want.value, got.value);
						fail_count++;
					end
					if (got.no_inv !== want.no_inv) begin
						$display("%0t: no_inverse expected %b actual %b", $time,
							want.no_inv, got.no_inv);
						fail_count++;
					end
				end
			end
			if (cfg_we)
				modulus = {33'd0, cfg_wdata};
			pending = answers.size();
		end
	end

endmodule

FILE: tb/prime_field_arithmetic_unit_tb.sv
// Testbench top: stimulus, configuration phases, stalls and verdict for the unit.
`timescale 1ns / 1ps

module prime_field_arithmetic_unit_tb;
	import pfau_pkg::*;

	localparam int STALL_LIMIT = 20000; // cycles with no beat before giving up
	localparam int RANDOM_ITEMS = 1200;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [MOD_W-1:0] cfg_wdata;
	int               fail_count;
	int               pending;
	int               idle_cycles = 0;
	bit               sink_quiet;     // no random backpressure
	bit               hold_off_req;   // ask the sink to stall for a long stretch
	bit               source_quiet;

	pfau_in_if  req();
	pfau_out_if rsp();

	prime_field_arithmetic_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req.sink),
		.rsp      (rsp.source)
	);

	pfau_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Interesting moduli: integer mode, p=1 (no inverses), small primes, a composite,
	// the largest 31-bit prime / value and another large prime.
	logic [MOD_W-1:0] moduli[8] = '{31'd0, 31'd1, 31'd2, 31'd7, 31'd15,
		31'd65521, 31'h7FFFFFFF, 31'd2147483629};

	function automatic logic [63:0] rand64();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		case ($urandom_range(0, 7))
			0: v = 64'h8000_0000_0000_0000;
			1: v = 64'h7FFF_FFFF_FFFF_FFFF;
			2: v = '1;
			3: v = '0;
			4: v = 64'($signed($urandom_range(0, 40)) - 20);
			default: ;
		endcase
		return v;
	endfunction

	// One request beat; random gap before it unless quiet. Valid stays up
	// after the beat so back-to-back beats need no second assignment.
	task automatic send_beat(mode_t m, logic [63:0] a, logic [63:0] b);
		while (!source_quiet && $urandom_range(0, 99) < 28) begin
			req.valid <= 0;
			@(negedge clk);
		end
		req.valid <= 1;
		req.mode <= m;
		req.operand_a <= a;
		req.operand_b <= b;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (600) @(negedge clk); // every result is back by now; this only adds idle time
	endtask

	task automatic write_modulus(logic [MOD_W-1:0] p);
		cfg_we <= 1;
		cfg_wdata <= p;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// sink side: random ready, optional long hold-off
	initial begin
		rsp.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				rsp.ready <= 0;
				repeat (3000) @(negedge clk);
				hold_off_req = 0;
			end else begin
				rsp.ready <= sink_quiet || ($urandom_range(0, 99) >= 28);
			end
		end
	end

	// watchdog on beats
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || hold_off_req)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int n;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		req.valid = 0;
		req.mode = 0;
		req.operand_a = 0;
		req.operand_b = 0;
		sink_quiet = 0;
		hold_off_req = 0;
		source_quiet = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: integer mode extremes and division corners
		send_beat(MODE_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1);
		send_beat(MODE_SUB, 64'h8000_0000_0000_0000, 64'd1);
		send_beat(MODE_MUL, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
		send_beat(MODE_MUL, 64'h1234_5678_9ABC_DEF0, 64'hFEDC_BA98_7654_3210);
		send_beat(MODE_DIV, 64'h8000_0000_0000_0000, '1);
		send_beat(MODE_DIV, 64'd17, 64'd0);
		send_beat(MODE_DIV, -64'sd17, 64'd5);
		send_beat(MODE_DIV, 64'd17, -64'sd5);
		drain();

		// directed: field mode with a prime, then p = 1 and a composite
		write_modulus(31'h7FFFFFFF);
		send_beat(MODE_ADD, 64'h8000_0000_0000_0000, '1);
		send_beat(MODE_SUB, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF);
		send_beat(MODE_MUL, '1, '1);
		send_beat(MODE_DIV, 64'd5, 64'h7FFF_FFFF);      // divisor reduces to zero
		send_beat(MODE_DIV, -64'sd3, 64'h8000_0000_0000_0000);
		drain();
		write_modulus(31'd1);
		send_beat(MODE_DIV, 64'd3, 64'd2);
		send_beat(MODE_ADD, 64'd3, 64'd2);
		drain();
		write_modulus(31'd15);
		send_beat(MODE_DIV, 64'd4, 64'd6);              // shares a factor
		send_beat(MODE_DIV, 64'd4, 64'd7);
		drain();

		// random phases across the moduli; one phase with no idling,
		// one with a long sink hold-off that fills the unit
		for (int ph = 0; ph < 12; ph++) begin
			write_modulus((ph < 8) ? moduli[ph] : 31'($urandom_range(1, 32'h7FFF_FFFF)));
			sink_quiet = (ph == 3);
			source_quiet = (ph == 3);
			n = RANDOM_ITEMS / 12;
			for (int i = 0; i < n; i++) begin
				if (ph == 5 && i == 10)
					hold_off_req = 1;
				send_beat(mode_t'($urandom_range(0, 3)), rand64(), rand64());
			end
			drain(); // sender pauses until every result is back
		end

		if (fail_count == 0 && pending == 0)
			$display(pfau_tb_pkg::PASS_TXT);
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: prime_field_arithmetic_unit.f
design/pfau_pkg.sv
design/pfau_in_if.sv
design/pfau_out_if.sv
design/pfau_dp.sv
design/pfau_ctrl.sv
design/prime_field_arithmetic_unit.sv
tb/pfau_tb_if.sv
tb/pfau_checker.sv
tb/prime_field_arithmetic_unit_tb.sv
